[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the acoustic line time step unit.
// Users must provide clk and arst_n in the scope where the macros expand.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, written for a property that starts on a transaction.
`define ASSERT_ON(label, cond, prop, msg) \
	`ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

[rtl/altsu_pkg.sv]
// Package of the acoustic line time step unit: sizes, request codes and
// fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package altsu_pkg;
	localparam int MAX_ELEMENTS = 1024;
	localparam int MAX_LINKS    = 16;
	localparam int VALUE_W      = 32;
	localparam int COEF_W       = 18;
	localparam int FRAC_W       = 16;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int LINK_W       = $clog2(MAX_LINKS);
	localparam int LCNT_W       = LINK_W + 1;
	localparam int PROD_W       = VALUE_W + COEF_W;
	localparam int ACC_W        = VALUE_W + 4;
	localparam int CFG_DATA_W   = 32;
	localparam int PADDR_W      = 3;
	localparam int COEFS_W      = 4 * COEF_W;

	typedef enum logic [2:0] {
		REQ_LOAD_COEF = 3'd0,
		REQ_LOAD_LINK = 3'd1,
		REQ_CLEAR     = 3'd2,
		REQ_STEP      = 3'd3,
		REQ_READ      = 3'd4
	} req_t;

	// Product rounded to Q16.16, half toward plus infinity.
	function automatic logic signed [ACC_W-1:0] rnd_q(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] t;
		t = x + $signed(PROD_W'(1) << (FRAC_W - 1));
		return ACC_W'(t >>> FRAC_W);
	endfunction

	// Saturate a wide sum to the value range.
	function automatic logic signed [VALUE_W-1:0] sat_v(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = $signed({{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}});
		lo = ~hi;
		if (x > hi) return VALUE_W'(hi);
		if (x < lo) return VALUE_W'(lo);
		return VALUE_W'(x);
	endfunction
endpackage
`default_nettype wire

[rtl/altsu_if.sv]
// Request and response channel interfaces of the acoustic line time step unit.
// Depends on altsu_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface altsu_req_if import altsu_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [2:0]                req_type;
	logic [IDX_W-1:0]          target_index;
	logic signed [COEF_W-1:0]  factor_left;
	logic signed [COEF_W-1:0]  factor_right;
	logic signed [COEF_W-1:0]  damping_coef;
	logic signed [COEF_W-1:0]  infinity_coef;
	logic [IDX_W-1:0]          master_element;
	logic [IDX_W-1:0]          slave_element;
	modport source (output valid, req_type, target_index, factor_left, factor_right,
		damping_coef, infinity_coef, master_element, slave_element, input ready);
	modport sink (input valid, req_type, target_index, factor_left, factor_right,
		damping_coef, infinity_coef, master_element, slave_element, output ready);
endinterface

interface altsu_rsp_if import altsu_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] pressure_value;
	logic signed [VALUE_W-1:0] difference_value;
	logic                      status;
	modport source (output valid, pressure_value, difference_value, status, input ready);
	modport sink (input valid, pressure_value, difference_value, status, output ready);
endinterface
`default_nettype wire

[rtl/acoustic_line_time_step_unit.sv]
// Acoustic line time step unit: sequencer, shared multiplier and table RAMs.
// Depends on altsu_pkg, altsu_if, altsu_ram and assert_macros.svh.
//
// Usage: requests arrive on req (valid/ready), one response per request
// leaves on rsp. A request is taken only while the unit is idle; the response
// sits in an output register, so the next request can be taken while the
// previous response still waits for rsp.ready.
// Work per request type, from the request transaction to the response:
//   load coefficients, load link, unknown code: straight to the finish state.
//   read element: a registered RAM read, then the finish state.
//   clear: one table row zeroed per cycle over all MAX_ELEMENTS rows.
//   step: for N elements and L links, a pressure pass over the elements, a
//   merge pass and a copy pass over the links, then a difference pass over the
//   elements; all products go through one 32x18 multiplier, and links with an
//   end at or past the element count are skipped in both link passes.
// After reset the unit sweeps all MAX_ELEMENTS rows of the pressure and
// difference RAMs before req.ready rises; APB writes are taken meanwhile.
// A finished request waits in the unit while the output register is full and
// rsp.ready is low. APB registers: element_count at 0, link_count at 4.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module acoustic_line_time_step_unit import altsu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	altsu_req_if.sink                  req,
	altsu_rsp_if.source                rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);
	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD_WAIT,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
		S_AC, S_A0, S_A1, S_A2,
		S_BC, S_B0, S_B1,
		S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6,
		S_FIN
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          idx_q;
	logic [LCNT_W-1:0]         lk_q;
	logic [CNT_W-1:0]          n_q;
	logic [LCNT_W-1:0]         lc_q;
	logic                      clr_rsp_q;
	logic signed [VALUE_W-1:0] dprev_q;
	logic signed [VALUE_W-1:0] cur_p_q;
	logic signed [VALUE_W-1:0] cur_d_q;
	logic [COEFS_W-1:0]        coef_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  mul_q;
	logic signed [VALUE_W-1:0] t_q;
	logic signed [VALUE_W-1:0] pm_q;
	logic signed [VALUE_W-1:0] res_p_q;
	logic signed [VALUE_W-1:0] res_d_q;
	logic                      res_st_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_p_q;
	logic signed [VALUE_W-1:0] out_d_q;
	logic                      out_st_q;
	logic [IDX_W-1:0]          master_q [MAX_LINKS];
	logic [IDX_W-1:0]          slave_q [MAX_LINKS];
	logic signed [VALUE_W-1:0] lp_q [MAX_LINKS];

	logic                      p_we, d_we, c_we;
	logic [IDX_W-1:0]          p_waddr, p_raddr, d_raddr, c_raddr;
	logic [VALUE_W-1:0]        p_wdata, d_wdata;
	logic [VALUE_W-1:0]        p_rdata, d_rdata;
	logic [COEFS_W-1:0]        c_rdata, c_wdata;
	logic signed [VALUE_W-1:0] p_rdata_s, d_rdata_s;
	logic signed [VALUE_W-1:0] mul_a;
	logic signed [COEF_W-1:0]  mul_b;
	logic [IDX_W-1:0]          idx_a;
	logic [IDX_W-1:0]          idx_nx;
	logic [LINK_W-1:0]         lk_a;
	logic                      link_skip;
	logic                      in_acc;
	logic                      last_el;
	logic                      out_free;
	logic signed [COEF_W-1:0]  k_left, k_right, k_damp, k_inf;
	logic [CNT_W-1:0]          cfg_n;
	logic [LCNT_W-1:0]         cfg_l;
	logic                      acc_st;
	state_t                    acc_state;

	assign idx_a     = idx_q[IDX_W-1:0];
	assign idx_nx    = IDX_W'(idx_q + CNT_W'(1));
	assign lk_a      = lk_q[LINK_W-1:0];
	assign p_rdata_s = $signed(p_rdata);
	assign d_rdata_s = $signed(d_rdata);
	assign k_left    = $signed(coef_q[4*COEF_W-1:3*COEF_W]);
	assign k_right   = $signed(c_rdata[3*COEF_W-1:2*COEF_W]);
	assign k_damp    = $signed(coef_q[2*COEF_W-1:COEF_W]);
	assign k_inf     = $signed(coef_q[COEF_W-1:0]);
	assign link_skip = ({1'b0, master_q[lk_a]} >= n_q) || ({1'b0, slave_q[lk_a]} >= n_q);
	assign last_el   = (idx_q == n_q - CNT_W'(1));
	assign in_acc    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign c_wdata   = {req.factor_left, req.factor_right, req.damping_coef, req.infinity_coef};

	// Channel outputs.
	assign req.ready            = (state_q == S_IDLE);
	assign rsp.valid            = out_valid_q;
	assign rsp.pressure_value   = out_p_q;
	assign rsp.difference_value = out_d_q;
	assign rsp.status           = out_st_q;

	// APB register file, clamped to the table sizes on write.
	assign pready = 1'b1;
	assign cfg_n  = (pwdata[CNT_W-1:0] > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
		: pwdata[CNT_W-1:0];
	assign cfg_l  = (pwdata[LCNT_W-1:0] > LCNT_W'(MAX_LINKS)) ? LCNT_W'(MAX_LINKS)
		: pwdata[LCNT_W-1:0];
	assign prdata = paddr[2] ? CFG_DATA_W'(lc_q) : CFG_DATA_W'(n_q);

	// Status and first state of a request as it is taken.
	always_comb begin
		acc_st    = 1'b0;
		acc_state = S_FIN;
		case (req.req_type)
			REQ_LOAD_COEF: acc_st = ({1'b0, req.target_index} >= n_q);
			REQ_LOAD_LINK: acc_st = (req.target_index >= IDX_W'(MAX_LINKS));
			REQ_CLEAR:     acc_state = S_CLR;
			REQ_STEP:      acc_state = (n_q == '0) ? S_FIN : S_P0;
			REQ_READ: begin
				if ({1'b0, req.target_index} >= n_q) begin
					acc_st = 1'b1;
				end else begin
					acc_state = S_RD_WAIT;
				end
			end
			default: acc_state = S_FIN;
		endcase
	end

	// RAM port control and operand selection for the shared multiplier.
	always_comb begin
		p_we    = 1'b0;
		d_we    = 1'b0;
		c_we    = 1'b0;
		p_waddr = idx_a;
		p_wdata = '0;
		d_wdata = '0;
		p_raddr = idx_a;
		d_raddr = idx_a;
		c_raddr = idx_a;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			S_CLR: begin
				p_we = 1'b1;
				d_we = 1'b1;
			end
			S_IDLE: begin
				p_raddr = req.target_index;
				d_raddr = req.target_index;
				c_we = in_acc && (req.req_type == REQ_LOAD_COEF)
					&& ({1'b0, req.target_index} < n_q);
			end
			S_P1: begin
				mul_a = d_rdata_s;
				mul_b = k_right;
			end
			S_P2: begin
				mul_a = dprev_q;
				mul_b = k_left;
			end
			S_P4: begin
				mul_a = sat_v(acc_q);
				mul_b = k_inf;
			end
			S_P5: begin
				p_we    = 1'b1;
				p_wdata = sat_v(rnd_q(mul_q));
			end
			S_A0: p_raddr = master_q[lk_a];
			S_A1: p_raddr = slave_q[lk_a];
			S_A2: begin
				p_we    = 1'b1;
				p_waddr = master_q[lk_a];
				p_wdata = sat_v(ACC_W'(pm_q) + ACC_W'(p_rdata_s) - ACC_W'(lp_q[lk_a]));
			end
			S_B0: p_raddr = master_q[lk_a];
			S_B1: begin
				p_we    = 1'b1;
				p_waddr = slave_q[lk_a];
				p_wdata = p_rdata;
			end
			S_D1: p_raddr = idx_nx;
			S_D3: begin
				mul_a = t_q;
				mul_b = k_damp;
			end
			S_D5: begin
				mul_a = t_q;
				mul_b = k_inf;
			end
			S_D6: begin
				d_we    = 1'b1;
				d_wdata = sat_v(rnd_q(mul_q));
			end
			default: begin
			end
		endcase
	end

	// Shared multiplier, registered product.
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	altsu_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_pressure_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	altsu_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_difference_ram (
		.clk(clk), .we(d_we), .waddr(idx_a), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	altsu_ram #(.WIDTH(COEFS_W), .DEPTH(MAX_ELEMENTS)) u_coef_ram (
		.clk(clk), .we(c_we), .waddr(req.target_index), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	// Link end tables, written by load link requests.
	always_ff @(posedge clk) begin
		if (in_acc && (req.req_type == REQ_LOAD_LINK)
			&& (req.target_index < IDX_W'(MAX_LINKS))) begin
			master_q[req.target_index[LINK_W-1:0]] <= req.master_element;
			slave_q[req.target_index[LINK_W-1:0]]  <= req.slave_element;
		end
	end

	// Sequencer with its working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			idx_q       <= '0;
			lk_q        <= '0;
			n_q         <= CNT_W'(MAX_ELEMENTS);
			lc_q        <= '0;
			clr_rsp_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_LINKS; k++) begin
				lp_q[k] <= '0;
			end
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2]) begin
					lc_q <= cfg_l;
				end else begin
					n_q <= cfg_n;
				end
			end
			// The finish state loads the output register itself.
			if (rsp.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == CNT_W'(MAX_ELEMENTS - 1)) begin
						state_q <= clr_rsp_q ? S_FIN : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						res_p_q   <= '0;
						res_d_q   <= '0;
						res_st_q  <= acc_st;
						idx_q     <= '0;
						lk_q      <= '0;
						dprev_q   <= '0;
						clr_rsp_q <= (req.req_type == REQ_CLEAR);
						state_q   <= acc_state;
					end
				end
				S_RD_WAIT: begin
					res_p_q <= p_rdata_s;
					res_d_q <= d_rdata_s;
					state_q <= S_FIN;
				end
				// Pressure pass.
				S_P0: state_q <= S_P1;
				S_P1: begin
					cur_d_q <= d_rdata_s;
					coef_q  <= c_rdata;
					acc_q   <= ACC_W'(p_rdata_s);
					state_q <= S_P2;
				end
				S_P2: begin
					acc_q   <= acc_q + rnd_q(mul_q);
					state_q <= S_P3;
				end
				S_P3: begin
					acc_q   <= acc_q + rnd_q(mul_q);
					state_q <= S_P4;
				end
				S_P4: state_q <= S_P5;
				S_P5: begin
					dprev_q <= cur_d_q;
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= last_el ? S_AC : S_P0;
				end
				// Merge pass over the links.
				S_AC: begin
					if (lk_q == lc_q) begin
						lk_q    <= '0;
						state_q <= S_BC;
					end else if (link_skip) begin
						lk_q <= lk_q + LCNT_W'(1);
					end else begin
						state_q <= S_A0;
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: begin
					pm_q    <= p_rdata_s;
					state_q <= S_A2;
				end
				S_A2: begin
					lk_q    <= lk_q + LCNT_W'(1);
					state_q <= S_AC;
				end
				// Copy pass over the links.
				S_BC: begin
					if (lk_q == lc_q) begin
						idx_q   <= '0;
						state_q <= S_D0;
					end else if (link_skip) begin
						lk_q <= lk_q + LCNT_W'(1);
					end else begin
						state_q <= S_B0;
					end
				end
				S_B0: state_q <= S_B1;
				S_B1: begin
					lp_q[lk_a] <= p_rdata_s;
					lk_q       <= lk_q + LCNT_W'(1);
					state_q    <= S_BC;
				end
				// Difference pass.
				S_D0: state_q <= S_D1;
				S_D1: begin
					cur_p_q <= p_rdata_s;
					cur_d_q <= d_rdata_s;
					coef_q  <= c_rdata;
					state_q <= S_D2;
				end
				S_D2: begin
					t_q <= sat_v(ACC_W'(cur_d_q) + ACC_W'(cur_p_q)
						- (last_el ? ACC_W'(0) : ACC_W'(p_rdata_s)));
					state_q <= S_D3;
				end
				S_D3: state_q <= S_D4;
				S_D4: begin
					t_q     <= sat_v(ACC_W'(t_q) - rnd_q(mul_q));
					state_q <= S_D5;
				end
				S_D5: state_q <= S_D6;
				S_D6: begin
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= last_el ? S_FIN : S_D0;
				end
				// Hand the response to the output register.
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_p_q     <= res_p_q;
						out_d_q     <= res_d_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Every accepted request leaves the idle state for its work.
	`ASSERT_ON(a_acc_leaves_idle, in_acc, ##1 (state_q != S_IDLE), "request not started")
	// Element passes never run past the element count.
	`ASSERT_ON(a_idx_in_range, (state_q == S_P0) || (state_q == S_D0), idx_q < n_q,
		"element index beyond count")
	// A new response appears only from the finish state.
	`ASSERT_ON(a_rsp_from_fin, $rose(out_valid_q), $past(state_q == S_FIN),
		"response without finished request")
endmodule
`default_nettype wire

[rtl/altsu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module altsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the acoustic line time step unit: directed and random
// requests, a scoreboard with its own line predictor, APB setup of the counts.
// Depends on altsu_pkg, altsu_if and the unit's RTL.

module tb_top;
	import altsu_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_ELEMENT_COUNT = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_LINK_COUNT    = 3'd4;
	localparam logic [2:0]         REQ_UNUSED_FIRST   = 3'd5;
	localparam logic [2:0]         REQ_UNUSED_LAST    = 3'd7;
	localparam logic               STATUS_DONE        = 1'b0;
	localparam logic               STATUS_RANGE       = 1'b1;
	localparam int                 LOADED_ELEMENTS    = 48;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [2:0]               kind;
		logic [IDX_W-1:0]         index;
		logic signed [COEF_W-1:0] left;
		logic signed [COEF_W-1:0] right;
		logic signed [COEF_W-1:0] damping;
		logic signed [COEF_W-1:0] infinity;
		logic [IDX_W-1:0]         master;
		logic [IDX_W-1:0]         slave;
	} line_request_t;

	typedef struct {
		logic [VALUE_W-1:0] pressure;
		logic [VALUE_W-1:0] difference;
		logic               status;
	} line_response_t;

	// Scoreboard: keeps its own copy of the line tables and the expected responses.
	class line_scoreboard;
		longint pressure[MAX_ELEMENTS];
		longint difference[MAX_ELEMENTS];
		longint left_f[MAX_ELEMENTS];
		longint right_f[MAX_ELEMENTS];
		longint damp_f[MAX_ELEMENTS];
		longint inf_f[MAX_ELEMENTS];
		int     link_master[MAX_LINKS];
		int     link_slave[MAX_LINKS];
		longint link_pressure[MAX_LINKS];
		int     element_count;
		int     link_count;
		int     errors;
		line_response_t expected_q[$];

		function new();
			foreach (pressure[i]) begin
				pressure[i] = 0;
				difference[i] = 0;
				left_f[i] = 0;
				right_f[i] = 0;
				damp_f[i] = 0;
				inf_f[i] = 0;
			end
			foreach (link_master[k]) begin
				link_master[k] = 0;
				link_slave[k] = 0;
				link_pressure[k] = 0;
			end
			element_count = MAX_ELEMENTS;
			link_count = 0;
			errors = 0;
		endfunction

		function void set_register(logic [PADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
			int v;
			if (addr == ADDR_ELEMENT_COUNT) begin
				v = int'(value & 32'h7ff);
				element_count = (v > MAX_ELEMENTS) ? MAX_ELEMENTS : v;
			end else if (addr == ADDR_LINK_COUNT) begin
				v = int'(value & 32'h1f);
				link_count = (v > MAX_LINKS) ? MAX_LINKS : v;
			end
		endfunction

		// Q16.16 times Q1.16, rounded half up.
		function longint scale(longint v, longint c);
			longint prod;
			prod = v * c + 64'sd32768;
			return prod >>> FRAC_W;
		endfunction

		function longint clamp(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function void run_time_step();
			longint sum;
			longint right_p;
			longint left_d;
			longint t;
			int m;
			int s;
			// Pressure pass from the old differences.
			for (int i = 0; i < element_count; i++) begin
				left_d = (i > 0) ? difference[i-1] : 0;
				sum = pressure[i] + scale(difference[i], right_f[i]) + scale(left_d, left_f[i]);
				pressure[i] = clamp(scale(clamp(sum), inf_f[i]));
			end
			// Merge the masters, then copy back to slaves and link buffers.
			for (int k = 0; k < link_count; k++) begin
				m = link_master[k];
				s = link_slave[k];
				if (m < element_count && s < element_count)
					pressure[m] = clamp(pressure[m] + pressure[s] - link_pressure[k]);
			end
			for (int k = 0; k < link_count; k++) begin
				m = link_master[k];
				s = link_slave[k];
				if (m < element_count && s < element_count) begin
					pressure[s] = pressure[m];
					link_pressure[k] = pressure[m];
				end
			end
			// Difference pass from the new pressures.
			for (int i = 0; i < element_count; i++) begin
				right_p = (i + 1 < element_count) ? pressure[i+1] : 0;
				t = clamp(difference[i] + pressure[i] - right_p);
				t = clamp(t - scale(t, damp_f[i]));
				difference[i] = clamp(scale(t, inf_f[i]));
			end
		endfunction

		function void note_request(line_request_t r);
			line_response_t e;
			e.pressure = '0;
			e.difference = '0;
			e.status = STATUS_DONE;
			case (r.kind)
				REQ_LOAD_COEF: begin
					if (r.index >= element_count) begin
						e.status = STATUS_RANGE;
					end else begin
						left_f[r.index] = r.left;
						right_f[r.index] = r.right;
						damp_f[r.index] = r.damping;
						inf_f[r.index] = r.infinity;
					end
				end
				REQ_LOAD_LINK: begin
					if (r.index >= MAX_LINKS) begin
						e.status = STATUS_RANGE;
					end else begin
						link_master[r.index] = r.master;
						link_slave[r.index] = r.slave;
					end
				end
				REQ_CLEAR: begin
					foreach (pressure[i]) begin
						pressure[i] = 0;
						difference[i] = 0;
					end
				end
				REQ_STEP: run_time_step();
				REQ_READ: begin
					if (r.index >= element_count) begin
						e.status = STATUS_RANGE;
					end else begin
						e.pressure = pressure[r.index][VALUE_W-1:0];
						e.difference = difference[r.index][VALUE_W-1:0];
					end
				end
				default: ;
			endcase
			expected_q.push_back(e);
		endfunction

		function void check_response(line_response_t got);
			line_response_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected response transaction: pressure %0d difference %0d status %0d",
					$signed(got.pressure), $signed(got.difference), got.status);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.pressure !== e.pressure) begin
				$error("pressure_value: expected %0d, got %0d", $signed(e.pressure),
					$signed(got.pressure));
				errors++;
			end
			if (got.difference !== e.difference) begin
				$error("difference_value: expected %0d, got %0d", $signed(e.difference),
					$signed(got.difference));
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	altsu_req_if req_ch();
	altsu_rsp_if rsp_ch();

	acoustic_line_time_step_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	line_scoreboard line_sb = new();
	idle_mode_t     idle_mode = IDLE_NONE;
	int             hold_off_request = 0;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Response side: check each transaction, then pick the next ready value.
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				line_sb.check_response('{rsp_ch.pressure_value, rsp_ch.difference_value,
					rsp_ch.status});
			if (hold_off_request > 0) begin
				hold_left = hold_off_request;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_mode == IDLE_RECEIVER) begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= 87);
			end else if (idle_mode == IDLE_BOTH) begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= 16);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic bit sender_idles();
		if (idle_mode == IDLE_SENDER) return ($urandom_range(0, 99) < 87);
		if (idle_mode == IDLE_BOTH) return ($urandom_range(0, 99) < 16);
		return 1'b0;
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_request(line_request_t r);
		while (sender_idles()) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= r.kind;
		req_ch.target_index   <= r.index;
		req_ch.factor_left    <= r.left;
		req_ch.factor_right   <= r.right;
		req_ch.damping_coef   <= r.damping;
		req_ch.infinity_coef  <= r.infinity;
		req_ch.master_element <= r.master;
		req_ch.slave_element  <= r.slave;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		line_sb.note_request(r);
	endtask

	// Lets every outstanding response arrive before the next register write.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (line_sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [PADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		line_sb.set_register(addr, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic line_request_t make_request(logic [2:0] kind, int index);
		line_request_t r;
		r.kind = kind;
		r.index = index[IDX_W-1:0];
		r.left = '0;
		r.right = '0;
		r.damping = '0;
		r.infinity = '0;
		r.master = '0;
		r.slave = '0;
		return r;
	endfunction

	// Coefficients: half fully random, half in a stable-looking range.
	function automatic line_request_t coef_request(int index);
		line_request_t r;
		r = make_request(REQ_LOAD_COEF, index);
		if ($urandom_range(0, 1)) begin
			r.left = COEF_W'($urandom);
			r.right = COEF_W'($urandom);
			r.damping = COEF_W'($urandom);
			r.infinity = COEF_W'($urandom);
		end else begin
			r.left = COEF_W'($signed($urandom_range(0, 80000)) - 40000);
			r.right = COEF_W'($signed($urandom_range(0, 80000)) - 40000);
			r.damping = COEF_W'($urandom_range(0, 3000));
			r.infinity = COEF_W'($urandom_range(60000, 65536));
		end
		return r;
	endfunction

	function automatic line_request_t link_request(int index, int span);
		line_request_t r;
		r = make_request(REQ_LOAD_LINK, index);
		if ($urandom_range(0, 9) == 0) begin
			r.master = IDX_W'($urandom);
			r.slave = IDX_W'($urandom);
		end else begin
			r.master = IDX_W'($urandom_range(0, span));
			r.slave = IDX_W'($urandom_range(0, span));
		end
		return r;
	endfunction

	function automatic line_request_t random_request(int count);
		int pick;
		int index;
		pick = $urandom_range(0, 99);
		if (count > 0 && $urandom_range(0, 9) != 0) index = $urandom_range(0, count - 1);
		else index = $urandom_range(0, MAX_ELEMENTS - 1);
		if (pick < 28) return coef_request(index);
		if (pick < 38) return link_request(($urandom_range(0, 7) == 0) ? index :
			$urandom_range(0, MAX_LINKS - 1), count + 1);
		if (pick < 41) return make_request(REQ_CLEAR, $urandom);
		if (pick < 65) return make_request(REQ_STEP, $urandom);
		if (pick < 95) return make_request(REQ_READ, index);
		return make_request(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), index);
	endfunction

	task automatic random_burst(int items);
		for (int j = 0; j < items; j++) send_request(random_request(line_sb.element_count));
	endtask

	task automatic read_all();
		for (int i = 0; i < line_sb.element_count && i < 24; i++)
			send_request(make_request(REQ_READ, i));
	endtask

	// Main sequence of phases.
	initial begin
		line_request_t r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.target_index = '0;
		req_ch.factor_left = '0;
		req_ch.factor_right = '0;
		req_ch.damping_coef = '0;
		req_ch.infinity_coef = '0;
		req_ch.master_element = '0;
		req_ch.slave_element = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-size count: the oversized write saturates; the low elements and
		// every link get loaded, plus the last element of the table.
		write_register(ADDR_ELEMENT_COUNT, 32'h7ff);
		write_register(ADDR_LINK_COUNT, 32'd0);
		for (int i = 0; i < LOADED_ELEMENTS; i++) send_request(coef_request(i));
		for (int k = 0; k < MAX_LINKS; k++) send_request(link_request(k, 15));
		r = make_request(REQ_LOAD_COEF, 0);
		r.left = 18'sh1ffff;
		r.right = 18'sh20000;
		r.damping = 18'sh20000;
		r.infinity = 18'sh1ffff;
		send_request(r);
		r = make_request(REQ_LOAD_COEF, MAX_ELEMENTS - 1);
		r.left = 18'sh20000;
		r.right = 18'sh1ffff;
		r.damping = 18'sh1ffff;
		r.infinity = 18'sh20000;
		send_request(r);
		// Link index out of range, and a link with both ends at the last element.
		send_request(link_request(MAX_LINKS, 3));
		send_request(link_request(MAX_ELEMENTS - 1, 3));
		r = make_request(REQ_LOAD_LINK, MAX_LINKS - 1);
		r.master = '1;
		r.slave = '1;
		send_request(r);
		for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
			send_request(make_request(3'(c), c));
		send_request(make_request(REQ_READ, MAX_ELEMENTS - 1));
		wait_idle();

		// Steps run over the loaded elements only.
		write_register(ADDR_ELEMENT_COUNT, CFG_DATA_W'(LOADED_ELEMENTS));
		send_request(make_request(REQ_STEP, 0));
		send_request(make_request(REQ_READ, 0));
		send_request(make_request(REQ_READ, LOADED_ELEMENTS - 1));
		send_request(make_request(REQ_CLEAR, 0));
		send_request(make_request(REQ_READ, 0));
		wait_idle();

		// Short line with all links, the link count written too large.
		write_register(ADDR_ELEMENT_COUNT, 32'd8);
		write_register(ADDR_LINK_COUNT, 32'd31);
		send_request(make_request(REQ_READ, 8));
		send_request(make_request(REQ_LOAD_COEF, 8));
		for (int j = 0; j < 3; j++) send_request(make_request(REQ_STEP, 0));
		read_all();
		idle_mode = IDLE_SENDER;
		random_burst(25);
		wait_idle();

		// Empty line: a step touches nothing and element requests fail.
		idle_mode = IDLE_NONE;
		write_register(ADDR_ELEMENT_COUNT, 32'd0);
		send_request(make_request(REQ_STEP, 0));
		send_request(make_request(REQ_READ, 0));
		send_request(make_request(REQ_LOAD_COEF, 0));
		wait_idle();

		// Single element with a few links.
		write_register(ADDR_ELEMENT_COUNT, 32'd1);
		write_register(ADDR_LINK_COUNT, 32'd3);
		send_request(make_request(REQ_STEP, 0));
		send_request(make_request(REQ_READ, 0));
		idle_mode = IDLE_RECEIVER;
		random_burst(20);
		wait_idle();

		// Medium line: main random run, including a long receiver hold-off.
		write_register(ADDR_ELEMENT_COUNT, 32'd37);
		write_register(ADDR_LINK_COUNT, 32'd5);
		idle_mode = IDLE_BOTH;
		random_burst(30);
		idle_mode = IDLE_NONE;
		hold_off_request = 600;
		for (int j = 0; j < 12; j++) begin
			send_request(make_request(REQ_STEP, 0));
			send_request(make_request(REQ_READ, $urandom_range(0, 36)));
		end
		random_burst(25);
		idle_mode = IDLE_RECEIVER;
		random_burst(25);
		idle_mode = IDLE_SENDER;
		random_burst(20);
		wait_idle();

		// Back to the longest loaded line for a couple of steps with every link.
		idle_mode = IDLE_BOTH;
		write_register(ADDR_ELEMENT_COUNT, CFG_DATA_W'(LOADED_ELEMENTS));
		write_register(ADDR_LINK_COUNT, 32'd16);
		send_request(make_request(REQ_STEP, 0));
		send_request(make_request(REQ_STEP, 0));
		send_request(make_request(REQ_READ, LOADED_ELEMENTS - 1));
		read_all();
		wait_idle();
		repeat (50) @(posedge clk);

		if (line_sb.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_top: done, errors");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/altsu_pkg.sv
rtl/altsu_if.sv
rtl/altsu_ram.sv
rtl/acoustic_line_time_step_unit.sv
bench/tb_top.sv
